// File: hw/rtl/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// File: hw/rtl/ilt_pkg.sv
`default_nettype none

package ilt_pkg;

   localparam int TOKEN_CHARS = 6;
   localparam int TEXT_BYTES = 6;
   localparam int KEEP_CHARS = (TOKEN_CHARS < TEXT_BYTES) ? TOKEN_CHARS : TEXT_BYTES;
   localparam int TEXT_W = 8 * TEXT_BYTES;
   localparam int DEFAULT_SEPARATOR_SLOTS = 8;
   localparam int MAX_RESULTS = 3;
   localparam int RSP_DATA_W = 80;
   localparam logic [7:0] SEPARATOR_RESET = 8'd32;
   localparam logic [7:0] MAX_WORDS_RESET = 8'd59;

   typedef enum logic [1:0] {
      CSR_SEPARATOR_CHARS = 2'd0,
      CSR_WORD_SEPARATOR_COUNT = 2'd1,
      CSR_MAX_WORDS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CLASS_ORDINARY = 2'd0,
      CLASS_SPACE = 2'd1,
      CLASS_WORD_SEP = 2'd2
   } class_type;

   typedef struct packed {
      logic char_valid;
      logic [7:0] char_code;
      logic line_end;
   } item_type;

   typedef struct packed {
      logic result_kind;
      logic [TEXT_W-1:0] token_text;
      logic [7:0] token_length;
      logic [7:0] token_start;
      logic [7:0] word_total;
      logic overflow;
      logic last_result;
   } result_type;

   function automatic result_type make_token(input logic [TEXT_W-1:0] text,
                                             input logic [7:0] length,
                                             input logic [7:0] start,
                                             input logic [7:0] total);
      result_type r;
      r.result_kind = 1'b0;
      r.token_text = text;
      r.token_length = length;
      r.token_start = start;
      r.word_total = total;
      r.overflow = 1'b0;
      r.last_result = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ilt_classify.sv
`default_nettype none

module ilt_classify
   import ilt_pkg::*;
#(
   parameter int SEPARATOR_SLOTS = DEFAULT_SEPARATOR_SLOTS
) (
   input  wire logic [7:0]                   char_code,
   input  wire logic [8*SEPARATOR_SLOTS-1:0] separators,
   input  wire logic [3:0]                   word_sep_count,
   output class_type                         char_class
);

   // lowest matching slot wins, zero byte is always a space
   always_comb begin
      char_class = CLASS_ORDINARY;
      for (int i = SEPARATOR_SLOTS - 1; i >= 0; i--) begin
         if (separators[8*i +: 8] != 8'd0 && separators[8*i +: 8] == char_code) begin
            char_class = (4'(i) < word_sep_count) ? CLASS_WORD_SEP : CLASS_SPACE;
         end
      end
      if (char_code == 8'd0) begin
         char_class = CLASS_SPACE;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ilt_line_state.sv
`default_nettype none

module ilt_line_state
   import ilt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_go,
   input  item_type        item,
   input  class_type       char_class,
   input  wire logic [7:0] max_words,
   output result_type      res_slots [MAX_RESULTS],
   output logic [1:0]      res_count
);

   logic [TEXT_W-1:0] text_ff, text_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] start_ff, start_in;
   logic open_ff, open_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] words_ff, words_in;
   logic lim_ff, lim_in;

   result_type res_a, res_b, res_c, res_s;
   logic a_vld, b_vld, c_vld;
   result_type cand [MAX_RESULTS];
   logic [MAX_RESULTS-1:0] cand_vld;

   always_comb begin
      pos_in = pos_ff;
      open_in = open_ff;
      text_in = text_ff;
      len_in = len_ff;
      start_in = start_ff;
      words_in = words_ff;
      lim_in = lim_ff;
      a_vld = 1'b0;
      b_vld = 1'b0;
      c_vld = 1'b0;
      res_a = '0;
      res_b = '0;
      res_c = '0;
      res_s = '0;

      if (item.char_valid) begin
         if (pos_ff != 8'hFF) begin
            pos_in = pos_ff + 8'd1;
         end
         if (!lim_ff) begin
            if (char_class == CLASS_ORDINARY) begin
               if (!open_ff) begin
                  open_in = 1'b1;
                  text_in = '0;
                  len_in = 8'd0;
                  start_in = pos_in;
               end
               for (int k = 0; k < KEEP_CHARS; k++) begin
                  if (len_in == 8'(k)) begin
                     text_in[TEXT_W-1-8*k -: 8] = item.char_code;
                  end
               end
               if (len_in != 8'hFF) begin
                  len_in = len_in + 8'd1;
               end
            end else begin
               // a space or separator closes the open run
               if (open_ff) begin
                  open_in = 1'b0;
                  text_in = '0;
                  len_in = 8'd0;
                  start_in = 8'd0;
                  if (words_ff >= max_words) begin
                     lim_in = 1'b1;
                  end else begin
                     words_in = words_ff + 8'd1;
                     a_vld = 1'b1;
                     res_a = make_token(text_ff, len_ff, start_ff, words_in);
                  end
               end
               if (char_class == CLASS_WORD_SEP && !lim_in) begin
                  if (words_in >= max_words) begin
                     lim_in = 1'b1;
                  end else begin
                     words_in = words_in + 8'd1;
                     b_vld = 1'b1;
                     res_b = make_token({item.char_code, {(TEXT_W-8){1'b0}}}, 8'd1,
                                        pos_in, words_in);
                  end
               end
            end
         end
      end

      if (item.line_end) begin
         if (open_in && !lim_in) begin
            if (words_in >= max_words) begin
               lim_in = 1'b1;
            end else begin
               words_in = words_in + 8'd1;
               c_vld = 1'b1;
               res_c = make_token(text_in, len_in, start_in, words_in);
            end
         end
         res_s.result_kind = 1'b1;
         res_s.word_total = words_in;
         res_s.overflow = lim_in;
         res_s.last_result = 1'b1;
         open_in = 1'b0;
         text_in = '0;
         len_in = 8'd0;
         start_in = 8'd0;
         pos_in = 8'd0;
         words_in = 8'd0;
         lim_in = 1'b0;
      end
   end

   // closed run and end-of-line close never occur together
   always_comb begin
      cand[0] = a_vld ? res_a : res_c;
      cand[1] = res_b;
      cand[2] = res_s;
      cand_vld = {item.line_end, b_vld, a_vld | c_vld};
      res_count = 2'd0;
      for (int j = 0; j < MAX_RESULTS; j++) begin
         res_slots[j] = '0;
      end
      for (int j = 0; j < MAX_RESULTS; j++) begin
         if (cand_vld[j]) begin
            res_slots[res_count] = cand[j];
            res_count = res_count + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_ff <= '0;
         len_ff <= 8'd0;
         start_ff <= 8'd0;
         open_ff <= 1'b0;
         pos_ff <= 8'd0;
         words_ff <= 8'd0;
         lim_ff <= 1'b0;
      end else if (item_go) begin
         text_ff <= text_in;
         len_ff <= len_in;
         start_ff <= start_in;
         open_ff <= open_in;
         pos_ff <= pos_in;
         words_ff <= words_in;
         lim_ff <= lim_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ilt_result_buffer.sv
`default_nettype none

module ilt_result_buffer
   import ilt_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  load,
   input  result_type load_slots [MAX_RESULTS],
   input  wire logic [1:0] load_count,
   input  wire logic  pop,
   output logic       can_load,
   output logic       head_valid,
   output result_type head
);

   result_type slots_ff [MAX_RESULTS];
   logic [1:0] cnt_ff;
   logic [1:0] ptr_ff;

   assign head_valid = (cnt_ff != 2'd0);
   assign head = slots_ff[ptr_ff];
   assign can_load = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         ptr_ff <= 2'd0;
      end else if (load) begin
         cnt_ff <= load_count;
         ptr_ff <= 2'd0;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
         ptr_ff <= ptr_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slots_ff <= load_slots;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/input_line_tokenizer.sv
// Line tokenizer: takes one character per req beat and returns token records and a line
// summary on rsp. An accepted beat is registered, then classified and applied to the line
// state, which loads its zero to three results into a three-entry result buffer; rsp
// sends one result per cycle from that buffer while rsp_tready is high. Beats with at
// most one result stream back to back while rsp is not stalled; a beat with more results
// holds the next one until the single rsp port has drained the buffer to its last entry.
// A result reaches rsp through the input register and the result buffer. Separator slots
// above SEPARATOR_SLOTS are not stored and never match.
`default_nettype none
`include "assert_macros.svh"

module input_line_tokenizer
   import ilt_pkg::*;
#(
   parameter int SEPARATOR_SLOTS = DEFAULT_SEPARATOR_SLOTS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,  // char_code
   input  wire logic                  req_tuser,  // char_valid
   input  wire logic                  req_tlast,  // line_end
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // token_text, token_length, token_start, word_total, overflow, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser,  // result_kind
   output logic                       rsp_tlast,  // last_result
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [63:0]           csr_data
);

   localparam int SEP_W = 8 * SEPARATOR_SLOTS;

   logic [SEP_W-1:0] sep_ff;
   logic [3:0] wsc_ff;
   logic [7:0] max_words_ff;

   logic in_vld_ff, in_vld_in;
   item_type item_ff;
   logic req_accept;
   logic item_go;
   logic can_load;
   logic rsp_pop;
   class_type char_class;
   result_type res_slots [MAX_RESULTS];
   logic [1:0] res_count;
   result_type head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= {{(SEP_W-8){1'b0}}, SEPARATOR_RESET};
         wsc_ff <= 4'd0;
         max_words_ff <= MAX_WORDS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEPARATOR_CHARS: begin
               sep_ff <= csr_data[SEP_W-1:0];
            end
            CSR_WORD_SEPARATOR_COUNT: begin
               wsc_ff <= csr_data[3:0];
            end
            CSR_MAX_WORDS: begin
               max_words_ff <= csr_data[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   // input register
   assign item_go = in_vld_ff && can_load;
   assign req_tready = !in_vld_ff || item_go;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_accept) begin
         in_vld_in = 1'b1;
      end else if (item_go) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.char_valid <= req_tuser;
         item_ff.char_code <= req_tdata;
         item_ff.line_end <= req_tlast;
      end
   end

   ilt_classify #(
      .SEPARATOR_SLOTS(SEPARATOR_SLOTS)
   ) u_classify (
      .char_code(item_ff.char_code),
      .separators(sep_ff),
      .word_sep_count(wsc_ff),
      .char_class(char_class)
   );

   ilt_line_state u_line_state (
      .clock(clock),
      .reset(reset),
      .item_go(item_go),
      .item(item_ff),
      .char_class(char_class),
      .max_words(max_words_ff),
      .res_slots(res_slots),
      .res_count(res_count)
   );

   assign rsp_pop = rsp_tvalid && rsp_tready;

   ilt_result_buffer u_result_buffer (
      .clock(clock),
      .reset(reset),
      .load(item_go),
      .load_slots(res_slots),
      .load_count(res_count),
      .pop(rsp_pop),
      .can_load(can_load),
      .head_valid(rsp_tvalid),
      .head(head)
   );

   assign rsp_tdata = {7'd0, head.overflow, head.word_total, head.token_start,
                       head.token_length, head.token_text};
   assign rsp_tuser = head.result_kind;
   assign rsp_tlast = head.last_result;

   `ASSERT_ALWAYS(a_kind_matches_last, clock, reset, !rsp_tvalid || (rsp_tlast == rsp_tuser))
   `ASSERT_IMPLY(a_token_nonzero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[55:48] != 8'd0 && rsp_tdata[63:56] != 8'd0)
   `ASSERT_NEXT(a_item_held, clock, reset, in_vld_ff && !item_go, in_vld_ff && $stable(item_ff))

endmodule

`default_nettype wire

// File: bench/input_line_tokenizer_tb.sv
`timescale 1ns / 1ps

module input_line_tokenizer_tb;
   import ilt_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'd0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = 2'd0;
   logic [63:0] csr_data = 64'd0;

   input_line_tokenizer i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register copies
   logic [63:0] sep_slots = {56'd0, SEPARATOR_RESET};
   logic [3:0] word_sep_count = 4'd0;
   logic [7:0] word_limit = MAX_WORDS_RESET;

   // line state
   logic [TEXT_W-1:0] tok_text = '0;
   logic [7:0] tok_len = 8'd0;
   logic [7:0] tok_start = 8'd0;
   logic tok_open = 1'b0;
   logic [7:0] line_pos = 8'd0;
   logic [7:0] words_stored = 8'd0;
   logic limit_reached = 1'b0;

   item_type pending_chars[$];
   result_type expected_results[$];
   int chars_queued = 0;
   int chars_accepted = 0;
   int mismatches = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit req_sent = 1'b0;

   function automatic class_type char_class(input logic [7:0] c);
      logic [7:0] slot;
      if (c == 8'd0)
         return CLASS_SPACE;
      for (int i = 0; i < 8; i++) begin
         slot = sep_slots[8*i +: 8];
         if (slot != 8'd0 && slot == c)
            return (i < word_sep_count) ? CLASS_WORD_SEP : CLASS_SPACE;
      end
      return CLASS_ORDINARY;
   endfunction

   function automatic void close_token();
      result_type r;
      if (words_stored >= word_limit) begin
         limit_reached = 1'b1;
      end else begin
         words_stored++;
         r.result_kind = 1'b0;
         r.token_text = tok_text;
         r.token_length = tok_len;
         r.token_start = tok_start;
         r.word_total = words_stored;
         r.overflow = 1'b0;
         r.last_result = 1'b0;
         expected_results.push_back(r);
      end
      tok_open = 1'b0;
      tok_text = '0;
      tok_len = 8'd0;
      tok_start = 8'd0;
   endfunction

   function automatic void tokenize_char(input logic valid, input logic [7:0] c,
                                         input logic line_end);
      class_type cls;
      result_type r;
      if (valid) begin
         if (line_pos != 8'd255)
            line_pos++;
         if (!limit_reached) begin
            cls = char_class(c);
            if (cls == CLASS_ORDINARY) begin
               if (!tok_open) begin
                  tok_open = 1'b1;
                  tok_text = '0;
                  tok_len = 8'd0;
                  tok_start = line_pos;
               end
               if (int'(tok_len) < KEEP_CHARS)
                  tok_text[TEXT_W-1-8*int'(tok_len) -: 8] = c;
               if (tok_len != 8'd255)
                  tok_len++;
            end else begin
               if (tok_open)
                  close_token();
               if (cls == CLASS_WORD_SEP && !limit_reached) begin
                  tok_text = '0;
                  tok_text[TEXT_W-1 -: 8] = c;
                  tok_len = 8'd1;
                  tok_start = line_pos;
                  close_token();
               end
            end
         end
      end
      if (line_end) begin
         if (tok_open && !limit_reached)
            close_token();
         r = '0;
         r.result_kind = 1'b1;
         r.word_total = words_stored;
         r.overflow = limit_reached;
         r.last_result = 1'b1;
         expected_results.push_back(r);
         tok_text = '0;
         tok_len = 8'd0;
         tok_start = 8'd0;
         tok_open = 1'b0;
         line_pos = 8'd0;
         words_stored = 8'd0;
         limit_reached = 1'b0;
      end
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result expected none actual kind %0d data %h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("result_kind", want.result_kind, rsp_tuser);
               check_field("token_text", want.token_text, rsp_tdata[47:0]);
               check_field("token_length", want.token_length, rsp_tdata[55:48]);
               check_field("token_start", want.token_start, rsp_tdata[63:56]);
               check_field("word_total", want.word_total, rsp_tdata[71:64]);
               check_field("overflow", want.overflow, rsp_tdata[72]);
               check_field("last_result", want.last_result, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            tokenize_char(req_tuser, req_tdata, req_tlast);
            req_sent = 1'b1;
            chars_accepted++;
         end
      end
   end

   always @(negedge clock) begin : drive_req
      item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_sent) begin
            req_sent = 1'b0;
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_chars.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= nxt.char_valid;
               req_tdata <= nxt.char_code;
               req_tlast <= nxt.line_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic add_char(input logic valid, input logic [7:0] c, input logic line_end);
      item_type it;
      it.char_valid = valid;
      it.char_code = c;
      it.line_end = line_end;
      pending_chars.push_back(it);
      chars_queued++;
   endtask

   // end_mode: 0 open line, 1 end on last char, 2 separate empty end beat
   task automatic add_text(input string s, input int end_mode);
      for (int i = 0; i < s.len(); i++)
         add_char(1'b1, s[i], end_mode == 1 && i == s.len() - 1);
      if (end_mode == 2)
         add_char(1'b0, 8'($urandom_range(255)), 1'b1);
   endtask

   function automatic logic [7:0] random_char();
      int r;
      r = $urandom_range(99);
      if (r < 30)
         return sep_slots[8*$urandom_range(7) +: 8];
      else if (r < 35)
         return 8'd0;
      else if (r < 85)
         return 8'("a") + 8'($urandom_range(25));
      else
         return 8'($urandom_range(255));
   endfunction

   task automatic add_random_line();
      int n;
      bit split_end;
      n = $urandom_range(10);
      split_end = (n == 0) || ($urandom_range(99) < 30);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 5)
            add_char(1'b0, 8'($urandom_range(255)), 1'b0);
         add_char(1'b1, random_char(), !split_end && i == n - 1);
      end
      if (split_end)
         add_char(1'b0, 8'($urandom_range(255)), 1'b1);
   endtask

   function automatic logic [63:0] random_slots();
      string pool;
      logic [63:0] s;
      int r;
      pool = ",.;:!?-' ";
      for (int k = 0; k < 8; k++) begin
         r = $urandom_range(99);
         if (r < 15)
            s[8*k +: 8] = 8'd0;
         else if (r < 85)
            s[8*k +: 8] = pool[$urandom_range(pool.len() - 1)];
         else
            s[8*k +: 8] = 8'($urandom_range(255));
      end
      return s;
   endfunction

   task automatic write_config(input logic [63:0] seps, input logic [3:0] count,
                               input logic [7:0] limit);
      csr_index_type idx;
      for (int i = 0; i < 3; i++) begin
         idx = csr_index_type'(i);
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= idx;
         case (idx)
            CSR_SEPARATOR_CHARS: csr_data <= seps;
            CSR_WORD_SEPARATOR_COUNT: csr_data <= {60'd0, count};
            default: csr_data <= {56'd0, limit};
         endcase
         do @(posedge clock); while (!csr_ready);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      sep_slots = seps;
      word_sep_count = count;
      word_limit = limit;
   endtask

   task automatic wait_drained();
      while (chars_accepted != chars_queued || expected_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0; stall_pct = 0; end
         1: begin send_idle_pct = 62; stall_pct = 0; end
         2: begin send_idle_pct = 0; stall_pct = 62; end
         default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
   endtask

   initial begin : stimulus
      int target;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: space only, no word separators
      set_idling(0);
      add_text("ab cd", 1);
      add_char(1'b0, 8'h00, 1'b1);
      add_char(1'b1, 8'h00, 1'b0);
      add_char(1'b1, "q", 1'b0);
      add_char(1'b0, 8'h5a, 1'b0);
      add_char(1'b0, 8'ha5, 1'b1);
      add_text("Lo", 0);
      add_char(1'b1, 8'h01, 1'b0);
      add_char(1'b1, 8'hff, 1'b0);
      add_text("nger", 1);
      wait_drained();

      // comma and period split words, unused zero slot, limit of two
      write_config(64'h0000_0000_2000_2e2c, 4'd3, 8'd2);
      add_text("x.", 1);
      add_text("a,b c", 1);
      add_text(" ,", 2);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: write_config({$urandom, $urandom}, 4'($urandom_range(8)),
                            8'($urandom_range(5)));
            1: write_config(64'h20, 4'd0, 8'd255);
            2: write_config(64'h2d00_203f_213b_2e2c, 4'd8, 8'd0);
            3: write_config(64'd0, 4'd0, 8'd3);
            4: write_config(64'hffff_ffff_ffff_ffff, 4'd8, 8'd59);
            default: write_config(random_slots(), 4'($urandom_range(8)),
                                  ($urandom_range(3) == 0) ? 8'd255
                                                           : 8'($urandom_range(6)));
         endcase
         set_idling(p % 4);
         if (p == 1) begin
            // saturating length and line position
            for (int i = 0; i < 257; i++)
               add_char(1'b1, 8'("a") + 8'($urandom_range(25)), 1'b0);
            add_text(" zz", 2);
         end
         target = chars_queued + 20;
         while (chars_queued < target)
            add_random_line();
         wait_drained();
      end

      if (mismatches == 0)
         $display("input_line_tokenizer_tb passed");
      else
         $display("input_line_tokenizer_tb failed");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("input_line_tokenizer_tb failed");
      $finish;
   end

endmodule
